// File: sv/rile_pkg.sv
// rile_pkg: shared constants, command and status codes, and the
// controller/datapath handshake structs for the ring indexed list engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rile_pkg;

  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 32;
  localparam int PTR_W     = $clog2(CAPACITY);
  localparam int CNT_W     = PTR_W + 1;
  localparam int CMD_W     = 4;
  localparam int ST_W      = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_GET        = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SET        = 4'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 4'd10;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 4'd11;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_BOUNDS   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  typedef struct packed {
    logic            load;        // capture input item
    logic            st_en;       // write result status
    logic [ST_W-1:0] st_code;
    logic            setup_ins;
    logic            setup_rem;
    logic            setup_read;
    logic            setup_scan;
    logic            walk;
    logic            scan;
    logic            found;
    logic            cap_val;
    logic            write_item;
    logic            clr;
    logic            fin_ins;
    logic            fin_rem;
    logic            publish;
  } rile_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             oob;        // idx >= count
    logic             over;       // idx > count
    logic             full;
    logic             empty;
    logic             match;
    logic             walk_done;
  } rile_stat_t;

endpackage
`default_nettype wire

// File: sv/rile_ram.sv
// rile_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wen,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/rile_dp.sv
// rile_dp: datapath with head pointer, count, walk pointers, ring store
// and result registers. Depends on rile_pkg and rile_ram.
`timescale 1ns / 1ps
`default_nettype none
module rile_dp
  import rile_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rile_cmd_t            ctl,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [CNT_W-1:0]     position,
  input  wire logic [WORD_BITS-1:0] item_value,
  output rile_stat_t                stat,
  output logic [WORD_BITS-1:0]      read_value,
  output logic [PTR_W-1:0]          found_index,
  output logic [ST_W-1:0]           status,
  output logic [CNT_W-1:0]          entry_count
);

  logic [PTR_W-1:0]     front;
  logic [CNT_W-1:0]     count;
  logic [CMD_W-1:0]     cmd;
  logic [CNT_W-1:0]     idx;
  logic [WORD_BITS-1:0] val;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     wr_ptr;
  logic [CNT_W-1:0]     left;
  logic                 dir_dn;
  logic                 pend;
  logic                 side_high;
  logic [PTR_W-1:0]     hit;
  logic [WORD_BITS-1:0] res_val;
  logic [PTR_W-1:0]     res_fi;
  logic [ST_W-1:0]      res_st;
  logic [WORD_BITS-1:0] rdata;
  logic                 wen;
  logic [PTR_W-1:0]     waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [CNT_W-1:0]     idx_in;
  logic [PTR_W-1:0]     slot_idx;
  logic                 high_side;
  logic                 match;

  assign slot_idx  = front + idx[PTR_W-1:0];
  assign high_side = idx > (count >> 1);
  assign match     = pend && (rdata == val);

  always_comb begin
    case (command)
      CMD_APPEND:                   idx_in = count;
      CMD_POP_BACK, CMD_PEEK_BACK:  idx_in = count - CNT_W'(1);
      CMD_POP_FRONT, CMD_PEEK_FRONT: idx_in = '0;
      default:                      idx_in = position;
    endcase
  end

  // one write port: walk moves, set, or the final insert write
  always_comb begin
    wen   = 1'b0;
    waddr = wr_ptr;
    wdata = rdata;
    if (ctl.walk && pend) begin
      wen = 1'b1;
    end else if (ctl.write_item) begin
      wen   = 1'b1;
      waddr = slot_idx;
      wdata = val;
    end else if (ctl.fin_ins) begin
      wen   = 1'b1;
      waddr = (side_high ? front : front - PTR_W'(1)) + idx[PTR_W-1:0];
      wdata = val;
    end
  end

  rile_ram #(.WIDTH(WORD_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      pend  <= 1'b0;
      left  <= '0;
    end else begin
      if (ctl.clr) begin
        front <= '0;
        count <= '0;
      end
      if (ctl.fin_ins) begin
        if (!side_high) front <= front - PTR_W'(1);
        count <= count + CNT_W'(1);
      end
      if (ctl.fin_rem) begin
        if (!side_high) front <= front + PTR_W'(1);
        count <= count - CNT_W'(1);
      end
      if (ctl.setup_ins) begin
        side_high <= high_side;
        pend      <= 1'b0;
        if (high_side) begin
          wr_ptr <= front + count[PTR_W-1:0];
          rd_ptr <= front + count[PTR_W-1:0] - PTR_W'(1);
          dir_dn <= 1'b1;
          left   <= count - idx;
        end else begin
          wr_ptr <= front - PTR_W'(1);
          rd_ptr <= front;
          dir_dn <= 1'b0;
          left   <= idx;
        end
      end
      if (ctl.setup_rem) begin
        side_high <= high_side;
        pend      <= 1'b0;
        wr_ptr    <= slot_idx;
        if (high_side) begin
          rd_ptr <= slot_idx + PTR_W'(1);
          dir_dn <= 1'b0;
          left   <= count - idx - CNT_W'(1);
        end else begin
          rd_ptr <= slot_idx - PTR_W'(1);
          dir_dn <= 1'b1;
          left   <= idx;
        end
      end
      if (ctl.setup_read) begin
        rd_ptr <= slot_idx;
      end
      if (ctl.setup_scan) begin
        rd_ptr <= front;
        left   <= count;
        pend   <= 1'b0;
        hit    <= '0;
        dir_dn <= 1'b0;
      end
      // walk and scan share the read pointer and the countdown
      if ((ctl.walk || ctl.scan) && !ctl.found) begin
        pend <= (left != '0);
        if (left != '0) begin
          rd_ptr <= dir_dn ? rd_ptr - PTR_W'(1) : rd_ptr + PTR_W'(1);
          left   <= left - CNT_W'(1);
        end
      end
      if (ctl.walk && pend) begin
        wr_ptr <= dir_dn ? wr_ptr - PTR_W'(1) : wr_ptr + PTR_W'(1);
      end
      if (ctl.scan && pend && !match) begin
        hit <= hit + PTR_W'(1);
      end
      if (ctl.found) begin
        idx    <= {1'b0, hit};
        res_fi <= hit;
        rd_ptr <= front + hit;
      end
    end
    if (ctl.load) begin
      cmd     <= command;
      idx     <= idx_in;
      val     <= item_value;
      res_val <= '0;
      res_fi  <= '0;
      res_st  <= ST_OK;
    end
    if (ctl.st_en) res_st <= ctl.st_code;
    if (ctl.cap_val) res_val <= rdata;
    if (ctl.publish) begin
      read_value  <= res_val;
      found_index <= res_fi;
      status      <= res_st;
      entry_count <= count;
    end
  end

  assign stat.cmd       = cmd;
  assign stat.oob       = idx >= count;
  assign stat.over      = idx > count;
  assign stat.full      = count == CAP_COUNT;
  assign stat.empty     = count == '0;
  assign stat.match     = match;
  assign stat.walk_done = (left == '0) && !pend;

endmodule
`default_nettype wire

// File: sv/rile_ctrl.sv
// rile_ctrl: command sequencer and channel handshake for the list engine.
// Depends on rile_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rile_ctrl
  import rile_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire rile_stat_t stat,
  output rile_cmd_t       ctl
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_RD1     = 4'd2;
  localparam logic [3:0] S_RD2     = 4'd3;
  localparam logic [3:0] S_MOVE    = 4'd4;
  localparam logic [3:0] S_FIN_INS = 4'd5;
  localparam logic [3:0] S_FIN_REM = 4'd6;
  localparam logic [3:0] S_SCAN    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state, state_next;
  logic       is_rem, is_rem_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ctl         = '0;
    state_next  = state;
    is_rem_next = is_rem;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next  = S_DONE;
        is_rem_next = 1'b0;
        case (stat.cmd)
          CMD_APPEND: begin
            if (stat.full) begin
              ctl.st_en = 1'b1; ctl.st_code = ST_FULL;
            end else begin
              ctl.setup_ins = 1'b1; state_next = S_MOVE;
            end
          end
          CMD_INSERT: begin
            if (stat.over) begin
              ctl.st_en = 1'b1; ctl.st_code = ST_BOUNDS;
            end else if (stat.full) begin
              ctl.st_en = 1'b1; ctl.st_code = ST_FULL;
            end else begin
              ctl.setup_ins = 1'b1; state_next = S_MOVE;
            end
          end
          CMD_GET, CMD_REMOVE_AT: begin
            if (stat.oob) begin
              ctl.st_en = 1'b1; ctl.st_code = ST_BOUNDS;
            end else begin
              ctl.setup_read = 1'b1;
              is_rem_next    = (stat.cmd == CMD_REMOVE_AT);
              state_next     = S_RD1;
            end
          end
          CMD_PEEK_BACK, CMD_PEEK_FRONT, CMD_POP_BACK, CMD_POP_FRONT: begin
            if (stat.empty) begin
              ctl.st_en = 1'b1; ctl.st_code = ST_EMPTY;
            end else begin
              ctl.setup_read = 1'b1;
              is_rem_next    = (stat.cmd == CMD_POP_BACK) || (stat.cmd == CMD_POP_FRONT);
              state_next     = S_RD1;
            end
          end
          CMD_SET: begin
            if (stat.oob) begin
              ctl.st_en = 1'b1; ctl.st_code = ST_BOUNDS;
            end else begin
              ctl.write_item = 1'b1;
            end
          end
          CMD_SEARCH, CMD_REMOVE_VAL: begin
            ctl.setup_scan = 1'b1;
            state_next     = S_SCAN;
          end
          CMD_CLEAR: ctl.clr = 1'b1;
          default: begin
            ctl.st_en = 1'b1; ctl.st_code = ST_BOUNDS;
          end
        endcase
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.match) begin
          ctl.found = 1'b1;
          if (stat.cmd == CMD_REMOVE_VAL) begin
            is_rem_next = 1'b1;
            state_next  = S_RD1;
          end else begin
            state_next = S_DONE;
          end
        end else if (stat.walk_done) begin
          ctl.st_en   = 1'b1;
          ctl.st_code = ST_NOTFOUND;
          state_next  = S_DONE;
        end
      end
      S_RD1: state_next = S_RD2;
      S_RD2: begin
        ctl.cap_val = 1'b1;
        if (is_rem) begin
          ctl.setup_rem = 1'b1;
          state_next    = S_MOVE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MOVE: begin
        ctl.walk = 1'b1;
        if (stat.walk_done) state_next = is_rem ? S_FIN_REM : S_FIN_INS;
      end
      S_FIN_INS: begin
        ctl.fin_ins = 1'b1; state_next = S_DONE;
      end
      S_FIN_REM: begin
        ctl.fin_rem = 1'b1; state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.publish = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      is_rem    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      is_rem <= is_rem_next;
      if (ctl.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/ring_indexed_list_engine.sv
// ring_indexed_list_engine: top level, joins the sequencer and the datapath.
// Depends on rile_pkg, rile_ctrl, rile_dp (which holds rile_ram).
//
//   channel  direction  handshake             payload
//   in       in         in_valid / in_stall   command, position, item_value
//   out      out        out_valid / out_stall read_value, found_index, status, entry_count
//
// a taken command is dispatched; set, clear and refused commands then publish, get and peek
// read one entry, insert and append move entries then write the item, remove and pop read the
// entry then move entries; search scans from the front; remove by value is its scan plus the remove
// insert and remove move the shorter side, so at most about half the count moves
// rst is synchronous and active high; head and count clear, store contents stay unknown
// a result waits in the output register while the next item is taken and worked on
`timescale 1ns / 1ps
`default_nettype none
module ring_indexed_list_engine
  import rile_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [CNT_W-1:0]     position,
  input  wire logic [WORD_BITS-1:0] item_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WORD_BITS-1:0]      read_value,
  output logic [PTR_W-1:0]          found_index,
  output logic [ST_W-1:0]           status,
  output logic [CNT_W-1:0]          entry_count
);

  // command and status between sequencer and datapath
  rile_cmd_t  ctl;
  rile_stat_t stat;

  rile_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  rile_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .command     (command),
    .position    (position),
    .item_value  (item_value),
    .stat        (stat),
    .read_value  (read_value),
    .found_index (found_index),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule
`default_nettype wire

// File: sv/rile_checker.sv
// rile_checker: port-level assertions for the list engine, bound to the top.
// Depends on rile_pkg and ring_indexed_list_engine.
`timescale 1ns / 1ps
`default_nettype none
module rile_checker
  import rile_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [WORD_BITS-1:0] read_value,
  input wire logic [PTR_W-1:0]     found_index,
  input wire logic [ST_W-1:0]      status,
  input wire logic [CNT_W-1:0]     entry_count
);

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_FULL))
    else $error("status code out of range");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_value == '0))
    else $error("read value not zero on failed command");

  a_notfound_idx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NOTFOUND) |-> (found_index == '0))
    else $error("found index not zero when not found");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= CAP_COUNT))
    else $error("entry count above capacity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind ring_indexed_list_engine rile_checker u_rile_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_value  (read_value),
  .found_index (found_index),
  .status      (status),
  .entry_count (entry_count)
);
`default_nettype wire

// File: tb/ring_indexed_list_checker.sv
// ring_indexed_list_checker: watches both channels of the ring indexed list
// engine, predicts each result from its own copy of the list, compares.
// Depends on rile_pkg.
`timescale 1ns / 1ps
module ring_indexed_list_checker
  import rile_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CMD_W-1:0]     command,
  input  logic [CNT_W-1:0]     position,
  input  logic [WORD_BITS-1:0] item_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [WORD_BITS-1:0] read_value,
  input  logic [PTR_W-1:0]     found_index,
  input  logic [ST_W-1:0]      status,
  input  logic [CNT_W-1:0]     entry_count,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);

  typedef struct packed {
    logic [WORD_BITS-1:0] rd;
    logic [PTR_W-1:0]     fi;
    logic [ST_W-1:0]      st;
    logic [CNT_W-1:0]     cnt;
  } list_result_t;

  // logical view of the list: index 0 is the front
  logic [WORD_BITS-1:0] list_words[$];
  list_result_t         result_queue[$];

  assign pending = result_queue.size();

  function automatic list_result_t apply_command(input logic [CMD_W-1:0] c,
      input logic [CNT_W-1:0] p, input logic [WORD_BITS-1:0] v);
    list_result_t r;
    int n;
    r = '0;
    r.st = ST_OK;
    n = list_words.size();
    case (c)
      CMD_APPEND: begin
        if (n >= CAPACITY) r.st = ST_FULL;
        else list_words.push_back(v);
      end
      CMD_GET: begin
        if (p >= n) r.st = ST_BOUNDS;
        else r.rd = list_words[p];
      end
      CMD_SET: begin
        if (p >= n) r.st = ST_BOUNDS;
        else list_words[p] = v;
      end
      CMD_INSERT: begin
        if (p > n) r.st = ST_BOUNDS;
        else if (n >= CAPACITY) r.st = ST_FULL;
        else list_words.insert(p, v);
      end
      CMD_SEARCH, CMD_REMOVE_VAL: begin
        int hit;
        hit = -1;
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && list_words[i] == v) hit = i;
        end
        if (hit < 0) r.st = ST_NOTFOUND;
        else begin
          r.fi = PTR_W'(hit);
          if (c == CMD_REMOVE_VAL) begin
            r.rd = list_words[hit];
            list_words.delete(hit);
          end
        end
      end
      CMD_REMOVE_AT: begin
        if (p >= n) r.st = ST_BOUNDS;
        else begin
          r.rd = list_words[p];
          list_words.delete(p);
        end
      end
      CMD_CLEAR: list_words.delete();
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (n == 0) r.st = ST_EMPTY;
        else if (c == CMD_POP_BACK) r.rd = list_words.pop_back();
        else r.rd = list_words.pop_front();
      end
      CMD_PEEK_BACK, CMD_PEEK_FRONT: begin
        if (n == 0) r.st = ST_EMPTY;
        else r.rd = (c == CMD_PEEK_BACK) ? list_words[n-1] : list_words[0];
      end
      default: r.st = ST_BOUNDS;
    endcase
    r.cnt = CNT_W'(list_words.size());
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fail_count   <= 0;
      results_seen <= 0;
      list_words.delete();
      result_queue.delete();
    end else begin
      if (in_valid && !in_stall)
        result_queue.push_back(apply_command(command, position, item_value));
      if (out_valid && !out_stall) begin
        list_result_t want;
        results_seen <= results_seen + 1;
        if (result_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result at %0t", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = result_queue.pop_front();
          if (want.rd !== read_value || want.fi !== found_index ||
              want.st !== status || want.cnt !== entry_count) begin
            if (fail_count < 10)
              $display("mismatch at %0t: exp rd=%h fi=%0d st=%0d cnt=%0d got rd=%h fi=%0d st=%0d cnt=%0d",
                       $time, want.rd, want.fi, want.st, want.cnt,
                       read_value, found_index, status, entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/ring_indexed_list_engine_tb.sv
// ring_indexed_list_engine_tb: stimulus and verdict for the ring indexed
// list engine. Depends on rile_pkg, the engine, ring_indexed_list_checker.
`timescale 1ns / 1ps
module ring_indexed_list_engine_tb;
  import rile_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     command;
  logic [CNT_W-1:0]     position;
  logic [WORD_BITS-1:0] item_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_BITS-1:0] read_value;
  logic [PTR_W-1:0]     found_index;
  logic [ST_W-1:0]      status;
  logic [CNT_W-1:0]     entry_count;
  int                   fail_count;
  int                   pending;
  int                   results_seen;

  // idling percentages, changed per phase
  int send_idle_pct;
  int recv_stall_pct;
  // long receiver hold-off, counted in cycles by the stall process
  int hold_cycles;

  // the stimulus keeps a rough count so it can steer indexes and values
  int              shadow_count;
  logic [WORD_BITS-1:0] recent_vals[$];

  ring_indexed_list_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .position(position), .item_value(item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .found_index(found_index),
    .status(status), .entry_count(entry_count)
  );

  ring_indexed_list_checker checker_inst (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .position(position), .item_value(item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .found_index(found_index),
    .status(status), .entry_count(entry_count),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous limit: about 800 items at worst-case walk and stall times
  initial begin
    #(64'd20 * 64'd3000000);
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // offer one item and hold it until accepted; random gaps before it
  // valid stays high after the accepting edge until the next call or drain
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [CNT_W-1:0] p,
                           input logic [WORD_BITS-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= c;
    position   <= p;
    item_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // rough tracking of the length for steering only
    case (c)
      CMD_APPEND, CMD_INSERT: if (shadow_count < CAPACITY) shadow_count++;
      CMD_CLEAR: shadow_count = 0;
      CMD_REMOVE_AT, CMD_POP_BACK, CMD_POP_FRONT, CMD_REMOVE_VAL:
        if (shadow_count > 0) shadow_count--;
      default: ;
    endcase
    if (c == CMD_APPEND || c == CMD_INSERT || c == CMD_SET) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > 32) void'(recent_vals.pop_front());
    end
  endtask

  function automatic logic [WORD_BITS-1:0] pick_value();
    if (recent_vals.size() > 0 && $urandom_range(1) == 1)
      return recent_vals[$urandom_range(recent_vals.size() - 1)];
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_position();
    case ($urandom_range(9))
      0: return CNT_W'($urandom_range(2**CNT_W - 1));   // mostly out of range
      1: return CNT_W'(shadow_count);
      2: return '0;
      default: return CNT_W'($urandom_range(shadow_count > 0 ? shadow_count - 1 : 0));
    endcase
  endfunction

  task automatic random_phase(input int n_items);
    logic [CMD_W-1:0] c;
    for (int k = 0; k < n_items; k++) begin
      // grow below 40 entries, shrink from 40 up, with occasional clear and unused codes
      case ($urandom_range(19))
        0:       c = CMD_CLEAR;
        1:       c = CMD_W'($urandom_range(15, 12));
        2, 3, 4: c = (shadow_count < 40) ? CMD_APPEND : CMD_POP_FRONT;
        5, 6:    c = CMD_INSERT;
        default: c = CMD_W'($urandom_range(11));
      endcase
      if (c == CMD_CLEAR && shadow_count < 20) c = CMD_APPEND;
      send_item(c, pick_position(), pick_value());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = '0;
    position = '0;
    item_value = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    shadow_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list cases, then every command with edge values
    send_item(CMD_POP_BACK, '0, '0);
    send_item(CMD_PEEK_FRONT, '0, '0);
    send_item(CMD_SEARCH, '0, 32'h0);
    send_item(CMD_REMOVE_VAL, '0, 32'h5);
    send_item(CMD_GET, '0, '0);
    send_item(CMD_INSERT, 9'd1, 32'h1);          // past the end
    send_item(CMD_INSERT, 9'd0, 32'hFFFF_FFFF);
    send_item(CMD_APPEND, '0, 32'h0);
    send_item(CMD_APPEND, 9'h1FF, 32'hA5A5_5A5A);
    send_item(CMD_INSERT, 9'd1, 32'h5A5A_A5A5);
    send_item(CMD_SET, 9'd2, 32'h1234_5678);
    send_item(CMD_SET, 9'd3, 32'h1);             // last entry
    send_item(CMD_GET, 9'd1, '0);
    send_item(CMD_GET, 9'h1FF, '0);
    send_item(CMD_SEARCH, '0, 32'h1234_5678);
    send_item(CMD_PEEK_BACK, '0, '0);
    send_item(CMD_PEEK_FRONT, '0, '0);
    send_item(CMD_REMOVE_VAL, '0, 32'h5A5A_A5A5);
    send_item(CMD_REMOVE_AT, 9'd5, '0);
    send_item(CMD_REMOVE_AT, 9'd0, '0);
    send_item(CMD_POP_FRONT, '0, '0);
    send_item(CMD_POP_BACK, '0, '0);
    send_item(4'd12, '0, '0);
    send_item(4'd15, 9'h1FF, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, '0, '0);

    // fill to capacity, then refused append and insert, both ends of full list
    for (int i = 0; i < CAPACITY; i++) send_item(CMD_APPEND, '0, $urandom);
    send_item(CMD_APPEND, '0, 32'h7);
    send_item(CMD_INSERT, 9'd100, 32'h7);
    send_item(CMD_INSERT, 9'd257, 32'h7);
    send_item(CMD_GET, 9'd255, '0);
    send_item(CMD_REMOVE_AT, 9'd200, '0);
    send_item(CMD_REMOVE_AT, 9'd20, '0);
    send_item(CMD_INSERT, 9'd230, $urandom);
    send_item(CMD_INSERT, 9'd3, $urandom);
    drain();

    // random phases under different idling mixes
    random_phase(130);
    send_idle_pct = 79;
    random_phase(130);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    random_phase(130);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    random_phase(100);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    random_phase(30);
    drain();

    $display("covered %0d results: all commands, empty, full, bounds and unused codes,",
             results_seen);
    $display("under sender gaps, receiver stalls and a long receiver hold-off");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
